@@ rtl/core/radix_to_ascii_digits_top_assert.svh @@
// Assertion macros for the radix-to-ASCII converter.
// Used by radix_to_ascii_digits_top; expects clk and arst_n in scope.
`ifndef RADIX_TO_ASCII_DIGITS_TOP_ASSERT_SVH
`define RADIX_TO_ASCII_DIGITS_TOP_ASSERT_SVH

// same-cycle implication
`define R2A_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r2a check failed");

// next-cycle implication
`define R2A_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("r2a check failed");

`endif

@@ rtl/core/r2a_pkg.sv @@
// Shared types, constants and the digit character lookup for the
// radix-to-ASCII converter. No dependencies.
package r2a_pkg;

	localparam int DEF_MAX_DIGITS  = 64;
	localparam int DEF_VALUE_WIDTH = 64;
	localparam int RADIX_W         = 5;
	localparam int DIGIT_W         = 4;
	localparam int CHAR_W          = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 64;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

	localparam logic [RADIX_W-1:0]    RADIX_RST      = 5'd10;
	localparam logic [RADIX_W-1:0]    RADIX_MIN      = 5'd2;
	localparam logic [RADIX_W-1:0]    RADIX_MAX      = 5'd16;
	localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RST = 64'h6665_6463_6261_3938;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

	function automatic logic [CHAR_W-1:0] char_lookup(
		input logic [DIGIT_W-1:0]    d,
		input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi
	);
		logic [5:0] sh;
		sh = {d[2:0], 3'b000};
		return d[3] ? hi[sh +: CHAR_W] : lo[sh +: CHAR_W];
	endfunction

endpackage

@@ rtl/core/r2a_cell.sv @@
// One digit cell of the conversion row: doubles its digit, adds the carry
// from its lower neighbor, reduces by the radix. Depends on r2a_pkg.
module r2a_cell import r2a_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [RADIX_W-1:0] radix,
	input  logic [DIGIT_W-1:0] digit_in,
	input  logic               carry_in,
	input  logic               vld_in,
	output logic [DIGIT_W-1:0] digit,
	output logic               carry,
	output logic               vld
);

	logic [DIGIT_W-1:0] digit_q;
	logic               carry_q;
	logic               vld_q;
	logic [RADIX_W-1:0] sum;
	logic [RADIX_W-1:0] red;
	logic               ge;

	assign sum = {digit_q, carry_in};
	assign ge  = (sum >= radix);
	assign red = ge ? (sum - radix) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			carry_q <= 1'b0;
			vld_q   <= 1'b0;
		end else if (ctl.clear) begin
			digit_q <= '0;
			carry_q <= 1'b0;
			vld_q   <= 1'b0;
		end else if (ctl.shift) begin
			digit_q <= digit_in;
			carry_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			vld_q   <= vld_in;
			carry_q <= vld_in & ge;
			if (vld_in) begin
				digit_q <= red[DIGIT_W-1:0];
			end
		end
	end

	assign digit = digit_q;
	assign carry = carry_q;
	assign vld   = vld_q;

endmodule

@@ rtl/core/radix_to_ascii_digits_top.sv @@
// Top level of the radix-to-ASCII converter: config registers, control,
// the row of r2a_cell digit cells and the output register. Uses r2a_pkg.
// Each value is shifted MSB first into a row of MAX_DIGITS digit cells;
// carries move one cell per cycle. The row then drains through its top
// cell one digit per cycle while the output is not stalled (leading zeros
// skipped). A new value is taken once the final digit sits in the output
// register. Radix 0..1 acts as 2, 17..31 as 16; out-of-range register
// indexes are ignored.
`include "radix_to_ascii_digits_top_assert.svh"
module radix_to_ascii_digits_top import r2a_pkg::*; #(
	parameter int MAX_DIGITS  = DEF_MAX_DIGITS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CONV_END = VALUE_WIDTH + MAX_DIGITS - 2;
	localparam int CNT_W    = $clog2(VALUE_WIDTH + MAX_DIGITS);
	localparam int REM_W    = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SCAN, ST_EMIT} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [REM_W-1:0]        rem_q;
	logic [VALUE_WIDTH-1:0]  val_q;
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       char_q;
	logic                    last_q;

	logic [RADIX_W-1:0]      radix_q;
	logic [CFG_DATA_W-1:0]   chars_lo_q;
	logic [CFG_DATA_W-1:0]   chars_hi_q;
	logic [RADIX_W-1:0]      radix_eff;

	logic                    accept;
	logic                    feed;
	logic                    top_zero;
	logic                    rem_one;
	logic                    load_out;
	cell_ctl_t               ctl;

	logic [DIGIT_W-1:0]      cell_digit [MAX_DIGITS];
	logic                    cell_carry [MAX_DIGITS];
	logic                    cell_vld   [MAX_DIGITS];

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RST;
			chars_lo_q <= CHARS_LOW_RST;
			chars_hi_q <= CHARS_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIX:      radix_q    <= cfg_data[RADIX_W-1:0];
				REG_CHARS_LOW:  chars_lo_q <= cfg_data;
				REG_CHARS_HIGH: chars_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	// control
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign feed     = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_WIDTH));
	assign top_zero = (cell_digit[MAX_DIGITS-1] == '0);
	assign rem_one  = (rem_q == REM_W'(1));
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		ctl.clear = accept;
		ctl.shift = load_out || ((state_q == ST_SCAN) && top_zero && !rem_one);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			val_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						val_q   <= value;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (feed) begin
						val_q <= val_q << 1;
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CONV_END)) begin
						rem_q   <= REM_W'(MAX_DIGITS);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!top_zero || rem_one) begin
						state_q <= ST_EMIT;
					end else begin
						rem_q <= rem_q - REM_W'(1);
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						char_q      <= char_lookup(cell_digit[MAX_DIGITS-1],
							chars_lo_q, chars_hi_q);
						last_q      <= rem_one;
						rem_q       <= rem_q - REM_W'(1);
						if (rem_one) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cell row, cell 0 holds the least significant digit
	for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
		if (k == 0) begin : g_first
			r2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.radix    (radix_eff),
				.digit_in ('0),
				.carry_in (val_q[VALUE_WIDTH-1]),
				.vld_in   (feed),
				.digit    (cell_digit[k]),
				.carry    (cell_carry[k]),
				.vld      (cell_vld[k])
			);
		end else begin : g_next
			r2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.radix    (radix_eff),
				.digit_in (cell_digit[k-1]),
				.carry_in (cell_carry[k-1]),
				.vld_in   (cell_vld[k-1]),
				.digit    (cell_digit[k]),
				.carry    (cell_carry[k]),
				.vld      (cell_vld[k])
			);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

	`R2A_ASSERT_NXT(a_accept_starts_conv, accept, state_q == ST_CONV)
	`R2A_ASSERT_IMP(a_no_shift_in_conv, state_q == ST_CONV, !ctl.shift)
	`R2A_ASSERT_IMP(a_rem_nonzero, state_q == ST_SCAN || state_q == ST_EMIT, rem_q != '0)
	`R2A_ASSERT_NXT(a_last_ends_item, load_out && rem_one, state_q == ST_IDLE && last_q)
	`R2A_ASSERT_NXT(a_out_hold, out_valid_q && out_stall, out_valid_q && $stable(char_q))

endmodule
